// ===== rtl/core/lap3_pkg.sv =====
// Shared constants and helpers for the 3x3 Laplacian edge filter.
package lap3_pkg;

   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 2048;

   localparam int PIX_W   = 16;
   localparam int SIZE_W  = 12;
   localparam int POS_W   = 11;
   localparam int ADDR_W  = $clog2(MAX_WIDTH);
   localparam int SUM_W   = PIX_W + 4;
   localparam int CSR_IDX_W = 1;

   localparam logic [SIZE_W-1:0] MIN_SIZE       = SIZE_W'(3);
   localparam logic [SIZE_W-1:0] MAX_WIDTH_SZ   = SIZE_W'(MAX_WIDTH);
   localparam logic [SIZE_W-1:0] MAX_HEIGHT_SZ  = SIZE_W'(MAX_HEIGHT);
   localparam logic [SIZE_W-1:0] WIDTH_RESET    = SIZE_W'(640);
   localparam logic [SIZE_W-1:0] HEIGHT_RESET   = SIZE_W'(480);

   localparam logic [PIX_W-1:0] EDGE_MAX = 16'hFF00;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   // Force a frame dimension into 3 .. limit.
   function automatic logic [SIZE_W-1:0] sat_size(input logic [SIZE_W-1:0] v,
                                                  input logic [SIZE_W-1:0] limit);
      logic [SIZE_W-1:0] res;
      if (v < MIN_SIZE) begin
         res = MIN_SIZE;
      end else if (v > limit) begin
         res = limit;
      end else begin
         res = v;
      end
      return res;
   endfunction

endpackage

// ===== rtl/core/laplacian_3x3_edge_filter.sv =====
// Top level of the streaming 3x3 four-neighbor Laplacian edge filter.
// Pixels (unsigned 8.8) arrive in raster order, one item per clock at full rate when
// req_stall is low; the block gives 4*center - up - down - left - right, clamped to
// 0 .. 255.0, for every interior pixel, in the cycle after the pixel at (row+1, col+1)
// is accepted. Border pixels give no result. Two 2048-entry line stores are read one
// column ahead, so the registered read data is ready when the next pixel comes and the
// kernel runs in the accepting cycle; its result is then registered. While a result
// waits under rsp_stall, req_stall is high and no pixel is taken. frame_width and
// frame_height are saturated to 3 .. 2048 on write and may be changed only while the
// block is idle.
module laplacian_3x3_edge_filter (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [lap3_pkg::PIX_W-1:0]          req_gray_q8,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [lap3_pkg::PIX_W-1:0]          rsp_edge_q8,
   output logic [lap3_pkg::POS_W-1:0]          rsp_out_row,
   output logic [lap3_pkg::POS_W-1:0]          rsp_out_col,
   output logic                                rsp_frame_last,
   input  logic                                csr_wr_en,
   input  logic [lap3_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lap3_pkg::SIZE_W-1:0]         csr_wr_data
);

   logic [lap3_pkg::SIZE_W-1:0] width_ff, height_ff;

   logic [lap3_pkg::PIX_W-1:0] upper_mem [lap3_pkg::MAX_WIDTH];
   logic [lap3_pkg::PIX_W-1:0] middle_mem [lap3_pkg::MAX_WIDTH];
   logic [lap3_pkg::PIX_W-1:0] upper_rd_ff, middle_rd_ff;
   logic [lap3_pkg::ADDR_W-1:0] rd_addr;

   logic [lap3_pkg::PIX_W-1:0] win_up_ff, win_mid_ff, win_mid_prev_ff, win_low_ff;

   logic [lap3_pkg::POS_W-1:0] row_ff, row_in, col_ff, col_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [lap3_pkg::PIX_W-1:0]  rsp_edge_ff;
   logic [lap3_pkg::POS_W-1:0]  rsp_row_ff, rsp_col_ff;
   logic                        rsp_last_ff;

   logic                        accept;
   logic                        hit;
   logic                        last;
   logic [lap3_pkg::SIZE_W-1:0] row_w, col_w, col_inc, row_inc;
   logic signed [lap3_pkg::SUM_W-1:0] sum;
   logic [lap3_pkg::PIX_W-1:0]  edge_val;

   // Configuration registers, saturated on write.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= lap3_pkg::WIDTH_RESET;
         height_ff <= lap3_pkg::HEIGHT_RESET;
      end else if (csr_wr_en) begin
         case (lap3_pkg::csr_index_type'(csr_index))
            lap3_pkg::CSR_FRAME_WIDTH: begin
               width_ff <= lap3_pkg::sat_size(csr_wr_data, lap3_pkg::MAX_WIDTH_SZ);
            end
            lap3_pkg::CSR_FRAME_HEIGHT: begin
               height_ff <= lap3_pkg::sat_size(csr_wr_data, lap3_pkg::MAX_HEIGHT_SZ);
            end
            default: begin
            end
         endcase
      end
   end

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   // Position bookkeeping.
   always_comb begin
      row_w   = {1'b0, row_ff};
      col_w   = {1'b0, col_ff};
      col_inc = col_w + lap3_pkg::SIZE_W'(1);
      row_inc = row_w + lap3_pkg::SIZE_W'(1);
      hit  = (row_w >= lap3_pkg::SIZE_W'(2)) && (col_w >= lap3_pkg::SIZE_W'(2)) &&
             (row_w < height_ff) && (col_w < width_ff);
      last = (row_w == height_ff - lap3_pkg::SIZE_W'(1)) &&
             (col_w == width_ff - lap3_pkg::SIZE_W'(1));
      row_in = row_ff;
      col_in = col_ff;
      if (accept) begin
         if (col_inc >= width_ff) begin
            col_in = '0;
            row_in = (row_inc >= height_ff) ? '0 : row_inc[lap3_pkg::POS_W-1:0];
         end else begin
            col_in = col_inc[lap3_pkg::POS_W-1:0];
            if (row_w >= height_ff) begin
               row_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   // Line stores: read the column of the next pixel, write the current column.
   assign rd_addr = reset ? '0 : col_in[lap3_pkg::ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (accept) begin
         upper_mem[col_ff[lap3_pkg::ADDR_W-1:0]]  <= middle_rd_ff;
         middle_mem[col_ff[lap3_pkg::ADDR_W-1:0]] <= req_gray_q8;
      end
      upper_rd_ff  <= upper_mem[rd_addr];
      middle_rd_ff <= middle_mem[rd_addr];
   end

   // Window: up and center at col-1, middle row at col-2, lower row at col-1.
   always_ff @(posedge clock) begin
      if (reset) begin
         win_up_ff       <= '0;
         win_mid_ff      <= '0;
         win_mid_prev_ff <= '0;
         win_low_ff      <= '0;
      end else if (accept) begin
         win_up_ff       <= upper_rd_ff;
         win_mid_ff      <= middle_rd_ff;
         win_mid_prev_ff <= win_mid_ff;
         win_low_ff      <= req_gray_q8;
      end
   end

   // Kernel and clamp.
   always_comb begin
      sum = $signed({4'b0000, win_mid_ff} << 2)
            - $signed({4'b0000, win_up_ff})
            - $signed({4'b0000, win_low_ff})
            - $signed({4'b0000, win_mid_prev_ff})
            - $signed({4'b0000, middle_rd_ff});
      if (sum < 0) begin
         edge_val = '0;
      end else if (sum > $signed({4'b0000, lap3_pkg::EDGE_MAX})) begin
         edge_val = lap3_pkg::EDGE_MAX;
      end else begin
         edge_val = sum[lap3_pkg::PIX_W-1:0];
      end
   end

   // Result register; a new item loads it only when it is empty or being taken.
   assign rsp_valid_in = accept ? hit : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && hit) begin
         rsp_edge_ff <= edge_val;
         rsp_row_ff  <= row_ff - lap3_pkg::POS_W'(1);
         rsp_col_ff  <= col_ff - lap3_pkg::POS_W'(1);
         rsp_last_ff <= last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_edge_q8    = rsp_edge_ff;
   assign rsp_out_row    = rsp_row_ff;
   assign rsp_out_col    = rsp_col_ff;
   assign rsp_frame_last = rsp_last_ff;

endmodule
